// ===== hw/rtl/spsub_pkg.sv =====
`timescale 1ns / 1ps

package spsub_pkg;

  // Sizes
  localparam int MAX_PATTERN_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LEN_W           = 5;
  localparam int IDX_W           = 3;
  localparam int CFG_W           = 64;
  localparam int BYTE_W          = 8;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PAT_LO   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAT_HI   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SWAP_LO  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SWAP_HI  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAT_LEN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SWAP_LEN = 3'd5;

  // What the back end has to emit for one item
  typedef enum logic [1:0] {
    CMD_PREFIX_BYTE, // matched prefix, then the mismatching byte
    CMD_PREFIX,      // matched prefix only (end of stream flush)
    CMD_SWAP         // full replacement run
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

  // Settled configuration shared by front and back
  typedef struct packed {
    logic [2*CFG_W-1:0] pattern;
    logic [2*CFG_W-1:0] swap;
    logic [LEN_W-1:0]   slen;
    logic [LEN_W-1:0]   rlen;
  } match_cfg_t;

  // Byte j of a 16-byte word, byte 0 in the low bits
  function automatic logic [BYTE_W-1:0] pick_byte(input logic [2*CFG_W-1:0] v,
                                                  input logic [3:0] j);
    pick_byte = v[{j, 3'b000} +: BYTE_W];
  endfunction

endpackage

// ===== hw/rtl/spsub_in_if.sv =====
`timescale 1ns / 1ps

interface spsub_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/spsub_out_if.sv =====
`timescale 1ns / 1ps

interface spsub_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hw/rtl/spsub_front.sv =====
`timescale 1ns / 1ps

module spsub_front (
  input  logic                clk,
  input  logic                rst_n,
  spsub_in_if.sink            in_chan,
  input  spsub_pkg::match_cfg_t cfg,
  input  logic                cfg_clear,
  input  logic                q_full,
  output logic                push,
  output spsub_pkg::cmd_t     push_cmd
);

  logic [spsub_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [spsub_pkg::LEN_W-1:0]  cnt_eff, cnt_inc;
  logic [spsub_pkg::BYTE_W-1:0] pat_b;
  logic                         acc, hit;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && in_chan.ready;

  // Compare against the next expected pattern byte
  assign cnt_eff = (cnt_r >= cfg.slen) ? '0 : cnt_r;
  assign pat_b   = spsub_pkg::pick_byte(cfg.pattern, cnt_eff[3:0]);
  assign hit     = (in_chan.data_byte == pat_b);
  assign cnt_inc = cnt_eff + spsub_pkg::LEN_W'(1);

  // Classify the item into a back-end command
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = spsub_pkg::CMD_PREFIX_BYTE;
    push_cmd.len  = cnt_eff;
    push_cmd.data = in_chan.data_byte;
    cnt_nxt       = cnt_r;
    if (acc) begin
      if (in_chan.end_of_stream) begin
        push          = (cnt_eff != '0);
        push_cmd.kind = spsub_pkg::CMD_PREFIX;
        cnt_nxt       = '0;
      end else if (hit) begin
        if (cnt_inc >= cfg.slen) begin
          push          = 1'b1;
          push_cmd.kind = spsub_pkg::CMD_SWAP;
          push_cmd.len  = cfg.slen;
          cnt_nxt       = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end else begin
        push    = 1'b1;
        cnt_nxt = '0;
      end
    end
    if (cfg_clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Match count never reaches the pattern length
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < cfg.slen) else $error("match count reached pattern length");

  // End of stream always leaves no pending prefix
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_chan.end_of_stream |=> cnt_r == '0)
    else $error("prefix left pending after end of stream");

endmodule

// ===== hw/rtl/spsub_queue.sv =====
`timescale 1ns / 1ps

module spsub_queue #(
  parameter int DEPTH = spsub_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spsub_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output spsub_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spsub_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // A push is only offered when there is room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");

endmodule

// ===== hw/rtl/spsub_back.sv =====
`timescale 1ns / 1ps

module spsub_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spsub_pkg::match_cfg_t cfg,
  input  logic                  head_valid,
  input  spsub_pkg::cmd_t       head_cmd,
  output logic                  pop,
  spsub_out_if.source           out_chan
);

  logic [spsub_pkg::LEN_W-1:0]  pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [spsub_pkg::BYTE_W-1:0] out_byte_r;
  logic                         out_last_r;
  logic [spsub_pkg::BYTE_W-1:0] gen_byte;
  logic                         gen_last, load;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.run_last = out_last_r;

  // Output register free or draining this cycle
  assign load = head_valid && (!out_valid_r || out_chan.ready);

  // Byte at the current run position
  always_comb begin
    unique case (head_cmd.kind)
      spsub_pkg::CMD_PREFIX_BYTE: begin
        if (pos_r < head_cmd.len) begin
          gen_byte = spsub_pkg::pick_byte(cfg.pattern, pos_r[3:0]);
          gen_last = 1'b0;
        end else begin
          gen_byte = head_cmd.data;
          gen_last = 1'b1;
        end
      end
      spsub_pkg::CMD_PREFIX: begin
        gen_byte = spsub_pkg::pick_byte(cfg.pattern, pos_r[3:0]);
        gen_last = (pos_r == head_cmd.len - spsub_pkg::LEN_W'(1));
      end
      spsub_pkg::CMD_SWAP: begin
        gen_byte = (pos_r < cfg.rlen) ? spsub_pkg::pick_byte(cfg.swap, pos_r[3:0])
                                      : '0;
        gen_last = (pos_r == head_cmd.len - spsub_pkg::LEN_W'(1));
      end
      default: begin
        gen_byte = head_cmd.data;
        gen_last = 1'b1;
      end
    endcase
  end

  assign pop = load && gen_last;

  always_comb begin
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = gen_last ? '0 : pos_r + spsub_pkg::LEN_W'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= gen_byte;
      out_last_r <= gen_last;
    end
  end

  // Finishing a command restarts the run position
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> pos_r == '0) else $error("run position not restarted");

  // A waiting command fills an empty output register
  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && !out_valid_r |=> out_valid_r)
    else $error("output register left empty with work pending");

endmodule

// ===== hw/rtl/stream_pattern_substitute.sv =====
`timescale 1ns / 1ps

// Fixed-length pattern substitution on a byte stream.
// in_chan carries one item per byte (data_byte) or an end-of-stream marker
// (end_of_stream, no byte). out_chan carries the substituted bytes; run_last
// marks the last byte caused by one input item. Both use valid/ready.
// The cfg_* port writes the pattern, replacement and lengths; any write to a
// defined register drops a partially matched prefix. Write only when idle.
// An accepted item is registered as a command in the queue; the back end
// then registers its bytes in the output register. The back end emits one
// byte per cycle while the receiver is ready; an item causes 0 to 16 bytes,
// and one that only extends a partial match costs nothing downstream. Input
// is accepted every cycle while the command queue between front and back
// (QUEUE_DEPTH entries) has room; a long replacement run or a stalled
// receiver fills it and then holds in_chan.ready low. Results wait in the
// output register while the receiver stalls; nothing is dropped.
// Reset clears the match count, the queue and the output valid, and loads
// the register defaults (pattern length 1, everything else zero).

module stream_pattern_substitute #(
  parameter int MAX_PATTERN = spsub_pkg::MAX_PATTERN_DEF,
  parameter int QUEUE_DEPTH = spsub_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  spsub_in_if.sink                    in_chan,
  spsub_out_if.source                 out_chan,
  input  logic                        cfg_we,
  input  logic [spsub_pkg::IDX_W-1:0] cfg_index,
  input  logic [spsub_pkg::CFG_W-1:0] cfg_wdata
);

  logic [spsub_pkg::CFG_W-1:0] pat_lo_r, pat_hi_r, swap_lo_r, swap_hi_r;
  logic [spsub_pkg::LEN_W-1:0] pat_len_r, swap_len_r;
  logic [spsub_pkg::LEN_W-1:0] slen;
  logic                        cfg_clear;
  spsub_pkg::match_cfg_t       mcfg;
  spsub_pkg::cmd_t             push_cmd, head_cmd;
  logic                        push, q_full, pop, head_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      swap_lo_r  <= '0;
      swap_hi_r  <= '0;
      pat_len_r  <= spsub_pkg::LEN_W'(1);
      swap_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spsub_pkg::REG_PAT_LO:   pat_lo_r   <= cfg_wdata;
        spsub_pkg::REG_PAT_HI:   pat_hi_r   <= cfg_wdata;
        spsub_pkg::REG_SWAP_LO:  swap_lo_r  <= cfg_wdata;
        spsub_pkg::REG_SWAP_HI:  swap_hi_r  <= cfg_wdata;
        spsub_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_wdata[spsub_pkg::LEN_W-1:0];
        spsub_pkg::REG_SWAP_LEN: swap_len_r <= cfg_wdata[spsub_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we && (cfg_index <= spsub_pkg::REG_SWAP_LEN);

  // Effective lengths: pattern 1..MAX_PATTERN, replacement no longer than it
  always_comb begin
    if (pat_len_r == '0) begin
      slen = spsub_pkg::LEN_W'(1);
    end else if (pat_len_r > spsub_pkg::LEN_W'(MAX_PATTERN)) begin
      slen = spsub_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      slen = pat_len_r;
    end
  end

  assign mcfg.pattern = {pat_hi_r, pat_lo_r};
  assign mcfg.swap    = {swap_hi_r, swap_lo_r};
  assign mcfg.slen    = slen;
  assign mcfg.rlen    = (swap_len_r < slen) ? swap_len_r : slen;

  spsub_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (mcfg),
    .cfg_clear (cfg_clear),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  spsub_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  spsub_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (mcfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule
